// ===== rtl/core/key_repeat_layer_mapper_defines.svh =====
// Assertion macros shared by the key repeat and layer mapper RTL.
// Needs nothing but a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef KEY_REPEAT_LAYER_MAPPER_DEFINES_SVH
`define KEY_REPEAT_LAYER_MAPPER_DEFINES_SVH

// Checked on every rising edge outside reset.
`define KRLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define KRLM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/krlm_pkg.sv =====
// Package of the key repeat and layer mapper: register codes, gate selector codes,
// default sizes and the two constant keycode layers. Depends on nothing.
package krlm_pkg;

  // Default matrix and timer sizes.
  localparam int unsigned ROWS_DEF      = 4;
  localparam int unsigned COLS_DEF      = 6;
  localparam int unsigned TIME_BITS_DEF = 32;

  // Field widths fixed by the interface.
  localparam int unsigned ROW_W     = 2;
  localparam int unsigned COL_W     = 3;
  localparam int unsigned NOW_W     = 32;
  localparam int unsigned KEY_W     = 5;
  localparam int unsigned DELAY_W   = 16;
  localparam int unsigned MOD_W     = 5;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 16;

  // Reset values of the configuration registers.
  localparam logic [KEY_W-1:0]   KEY_NONE          = 5'd24;
  localparam logic [DELAY_W-1:0] FIRST_DELAY_RST   = 16'd560;
  localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST  = 16'd40;
  localparam logic [DELAY_W-1:0] REARM_DELAY_RST   = 16'd16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHIFT_KEY    = 4'd0,
    CFG_WIN_KEY      = 4'd1,
    CFG_CONTROL_KEY  = 4'd2,
    CFG_ALT_KEY      = 4'd3,
    CFG_LAYER_KEY    = 4'd4,
    CFG_FIRST_DELAY  = 4'd5,
    CFG_REPEAT_DELAY = 4'd6,
    CFG_REARM_DELAY  = 4'd7
  } cfg_idx_e;

  // Which delay gates the next press of a key.
  typedef enum logic [1:0] {
    GATE_FIRST  = 2'd0,
    GATE_REPEAT = 2'd1,
    GATE_REARM  = 2'd2
  } gate_sel_e;

  // Keycode layers, four rows of six columns.
  localparam int unsigned TBL_ROWS = 4;
  localparam int unsigned TBL_COLS = 6;

  localparam logic [CODE_W-1:0] FIRST_LAYER [TBL_ROWS][TBL_COLS] = '{
    '{8'd42, 8'd19, 8'd18, 8'd12, 8'd24, 8'd28},
    '{8'd52, 8'd51, 8'd15, 8'd14, 8'd13, 8'd11},
    '{8'd0,  8'd56, 8'd55, 8'd54, 8'd16, 8'd17},
    '{8'd0,  8'd0,  8'd0,  8'd0,  8'd44, 8'd40}
  };

  localparam logic [CODE_W-1:0] UP_LAYER [TBL_ROWS][TBL_COLS] = '{
    '{8'd46, 8'd45, 8'd39, 8'd38, 8'd37, 8'd36},
    '{8'd46, 8'd45, 8'd39, 8'd38, 8'd37, 8'd36},
    '{8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0},
    '{8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0}
  };

  // Keycode of a table cell in the chosen layer; cells outside the tables read as zero.
  function automatic logic [CODE_W-1:0] layer_code(input logic up,
                                                   input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    logic [CODE_W-1:0] code;
    code = '0;
    if ((32'(row) < TBL_ROWS) && (32'(col) < TBL_COLS)) begin
      code = up ? UP_LAYER[row][col] : FIRST_LAYER[row][col];
    end
    return code;
  endfunction

endpackage

// ===== rtl/core/key_repeat_layer_mapper.sv =====
// Top level of the key repeat and layer mapper: typematic gating per key, modifier
// flags, a held layer and keycode lookup. Depends on krlm_pkg and the defines header.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-----------------------------------------
//   in      | to block  | in_valid_i / in_stall_o    | key_row_i, key_col_i, released_i, now_ms_i
//   out     | from block| out_valid_o / out_stall_i  | modifier_bits_o, keycode_o
//   cfg     | to block  | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_wdata_i
//
// One item is taken every cycle while the input is not stalled. An item is captured in the
// input register and is written to the result register when it advances; the
// rate is set by the single compare-and-update pass on the per-key state registers.
// Reset clears every per-key flag, gate selector and timestamp at once, so the block
// takes items from the first cycle after reset. A stall at the output holds the result
// register, and the input stalls only while both registers are full.
`include "key_repeat_layer_mapper_defines.svh"

module key_repeat_layer_mapper #(
  parameter int unsigned ROWS      = krlm_pkg::ROWS_DEF,
  parameter int unsigned COLS      = krlm_pkg::COLS_DEF,
  parameter int unsigned TIME_BITS = krlm_pkg::TIME_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Scan event channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [krlm_pkg::ROW_W-1:0]        key_row_i,
  input  logic [krlm_pkg::COL_W-1:0]        key_col_i,
  input  logic                              released_i,
  input  logic [krlm_pkg::NOW_W-1:0]        now_ms_i,
  // Result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [krlm_pkg::MOD_W-1:0]        modifier_bits_o,
  output logic [krlm_pkg::CODE_W-1:0]       keycode_o,
  // Configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [krlm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [krlm_pkg::CFG_DAT_W-1:0]    cfg_wdata_i
);
  import krlm_pkg::*;

  // Number of keys and the width of a key index. Positions are compared against the
  // 5-bit role registers, so the compare width is at least that wide.
  localparam int unsigned NKEYS    = ROWS * COLS;
  localparam int unsigned POS_W    = (NKEYS > 1) ? $clog2(NKEYS) : 1;
  localparam int unsigned CMP_W    = (POS_W > KEY_W) ? POS_W : KEY_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are to arrive only while the block is idle; the
  // block itself does not enforce this, and the port is always ready.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0]   shift_key_q, win_key_q, control_key_q, alt_key_q, layer_key_q;
  logic [DELAY_W-1:0] first_delay_q, repeat_delay_q, rearm_delay_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_key_q    <= KEY_NONE;
      win_key_q      <= KEY_NONE;
      control_key_q  <= KEY_NONE;
      alt_key_q      <= KEY_NONE;
      layer_key_q    <= KEY_NONE;
      first_delay_q  <= FIRST_DELAY_RST;
      repeat_delay_q <= REPEAT_DELAY_RST;
      rearm_delay_q  <= REARM_DELAY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SHIFT_KEY:    shift_key_q    <= cfg_wdata_i[KEY_W-1:0];
        CFG_WIN_KEY:      win_key_q      <= cfg_wdata_i[KEY_W-1:0];
        CFG_CONTROL_KEY:  control_key_q  <= cfg_wdata_i[KEY_W-1:0];
        CFG_ALT_KEY:      alt_key_q      <= cfg_wdata_i[KEY_W-1:0];
        CFG_LAYER_KEY:    layer_key_q    <= cfg_wdata_i[KEY_W-1:0];
        CFG_FIRST_DELAY:  first_delay_q  <= cfg_wdata_i[DELAY_W-1:0];
        CFG_REPEAT_DELAY: repeat_delay_q <= cfg_wdata_i[DELAY_W-1:0];
        CFG_REARM_DELAY:  rearm_delay_q  <= cfg_wdata_i[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. The item in it is processed in the cycle in which the result
  // register is empty or being emptied.
  // ---------------------------------------------------------------------------
  logic                 in_valid_q;
  logic [ROW_W-1:0]     row_q;
  logic [COL_W-1:0]     col_q;
  logic                 released_q;
  logic [NOW_W-1:0]     now_q;
  logic                 out_valid_q;
  logic                 advance;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      row_q      <= key_row_i;
      col_q      <= key_col_i;
      released_q <= released_i;
      now_q      <= now_ms_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-key state and global flags. All of it is read and written at the position
  // of the item in the input register, so the following item always sees the
  // state that this one leaves.
  // ---------------------------------------------------------------------------
  logic                 key_down_q [NKEYS];
  gate_sel_e            gate_sel_q [NKEYS];
  logic [TIME_BITS-1:0] last_ms_q  [NKEYS];
  logic                 shift_held_q, win_held_q, control_held_q, alt_held_q, up_layer_q;

  logic                 in_range;
  logic [CMP_W-1:0]     pos;
  logic [POS_W-1:0]     idx;
  logic                 is_shift, is_win, is_control, is_alt, is_layer, has_role;
  logic [TIME_BITS-1:0] now_t, elapsed, gate_t;
  logic [DELAY_W-1:0]   gate_ms;
  logic                 press_ok;
  logic                 key_write;
  logic                 shift_d, win_d, control_d, alt_d, up_layer_d;
  logic [CODE_W-1:0]    code_d;
  logic [MOD_W-1:0]     mod_d;

  assign in_range = (32'(row_q) < ROWS) && (32'(col_q) < COLS);
  assign pos      = CMP_W'(row_q) * CMP_W'(COLS) + CMP_W'(col_q);
  assign idx      = pos[POS_W-1:0];

  assign is_shift   = (pos == CMP_W'(shift_key_q));
  assign is_win     = (pos == CMP_W'(win_key_q));
  assign is_control = (pos == CMP_W'(control_key_q));
  assign is_alt     = (pos == CMP_W'(alt_key_q));
  assign is_layer   = (pos == CMP_W'(layer_key_q));
  assign has_role   = is_shift || is_win || is_control || is_alt || is_layer;

  // The gate selector picks one of the three delays; the spare code acts as the
  // first delay.
  always_comb begin
    unique case (gate_sel_q[idx])
      GATE_REPEAT: gate_ms = repeat_delay_q;
      GATE_REARM:  gate_ms = rearm_delay_q;
      default:     gate_ms = first_delay_q;
    endcase
  end

  // Elapsed time wraps with the timer width, so a plain subtraction is enough.
  assign now_t    = TIME_BITS'(now_q);
  assign gate_t   = TIME_BITS'(gate_ms);
  assign elapsed  = now_t - last_ms_q[idx];
  assign press_ok = !released_q && (elapsed >= gate_t);
  assign key_write = advance && in_range && (released_q || press_ok);

  // Modifier and layer flags after this item. A release clears every role the key
  // holds; an accepted press sets them. Keys with any role emit no keycode.
  always_comb begin
    shift_d    = shift_held_q;
    win_d      = win_held_q;
    control_d  = control_held_q;
    alt_d      = alt_held_q;
    up_layer_d = up_layer_q;
    code_d     = '0;
    if (in_range) begin
      if (released_q) begin
        if (is_shift)   shift_d    = 1'b0;
        if (is_win)     win_d      = 1'b0;
        if (is_control) control_d  = 1'b0;
        if (is_alt)     alt_d      = 1'b0;
        if (is_layer)   up_layer_d = 1'b0;
      end else if (press_ok) begin
        if (is_shift)   shift_d    = 1'b1;
        if (is_win)     win_d      = 1'b1;
        if (is_control) control_d  = 1'b1;
        if (is_alt)     alt_d      = 1'b1;
        if (is_layer)   up_layer_d = 1'b1;
        if (!has_role) begin
          code_d = layer_code(up_layer_q, row_q, col_q);
        end
      end
    end
  end

  // Modifier bits: shift 2, alt 4, win 8, control 16; bit 0 is always zero.
  assign mod_d = {control_d, win_d, alt_d, shift_d, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NKEYS; k++) begin
        key_down_q[k] <= 1'b0;
        gate_sel_q[k] <= GATE_FIRST;
        last_ms_q[k]  <= '0;
      end
      shift_held_q   <= 1'b0;
      win_held_q     <= 1'b0;
      control_held_q <= 1'b0;
      alt_held_q     <= 1'b0;
      up_layer_q     <= 1'b0;
    end else if (advance) begin
      shift_held_q   <= shift_d;
      win_held_q     <= win_d;
      control_held_q <= control_d;
      alt_held_q     <= alt_d;
      up_layer_q     <= up_layer_d;
      if (key_write) begin
        if (released_q) begin
          key_down_q[idx] <= 1'b0;
          gate_sel_q[idx] <= GATE_REARM;
        end else begin
          // After the first accepted press of a hold the next waits the first delay, after later ones the repeat delay.
          key_down_q[idx] <= 1'b1;
          gate_sel_q[idx] <= key_down_q[idx] ? GATE_REPEAT : GATE_FIRST;
          last_ms_q[idx]  <= now_t;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  logic [MOD_W-1:0]  mod_q;
  logic [CODE_W-1:0] code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      mod_q  <= mod_d;
      code_q <= code_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign modifier_bits_o = mod_q;
  assign keycode_o       = code_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The input only stalls when a result is held back by the output.
  `KRLM_ASSERT_ALWAYS(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled without a held result")
  // Every processed item lands in the result register.
  `KRLM_ASSERT(a_result_loaded, advance |=> out_valid_o, "processed item produced no result")
  // Releases and role keys never emit a keycode.
  `KRLM_ASSERT(a_no_code_role, (advance && (released_q || has_role)) |=> (keycode_o == '0), "keycode from a release or a role key")
  // Releasing the shift key clears the shift bit of the result.
  `KRLM_ASSERT(a_shift_release, (advance && in_range && released_q && is_shift) |=> !modifier_bits_o[1], "shift still held after its release")

endmodule
